@@ hw/rtl/hmca_pkg.sv @@
`default_nettype none

package hmca_pkg;

   // Field widths fixed by the beat formats
   localparam int IdWidth       = 16;
   localparam int WeightWidth   = 32;
   localparam int LevelWidth    = 2;
   localparam int PartsWidth    = 9;
   localparam int DistWidth     = 16;
   localparam int CostWidth     = 64;
   localparam int CsrIndexWidth = 3;
   localparam int CsrDataWidth  = 16;

   // Hardware levels, stride and reciprocal widths
   localparam int HwLevels      = 3;
   localparam int StrideWidth   = 2 * PartsWidth;
   localparam int RecipWidth    = 33;
   localparam int RecipShift    = 32;
   localparam int ProdWidth     = IdWidth + RecipWidth;
   localparam int CostProdWidth = WeightWidth + DistWidth;

   // Work queue between front and back end
   localparam int QueueDepth    = 4;
   localparam int QueuePtrWidth = $clog2(QueueDepth);
   localparam int QueueCntWidth = $clog2(QueueDepth + 1);

   // Configuration register map
   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_LEVEL_COUNT = 3'd0,
      CSR_PARTS0      = 3'd1,
      CSR_PARTS1      = 3'd2,
      CSR_PARTS2      = 3'd3,
      CSR_DIST0       = 3'd4,
      CSR_DIST1       = 3'd5,
      CSR_DIST2       = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [IdWidth-1:0]     src_block;
      logic [IdWidth-1:0]     dst_block;
      logic [WeightWidth-1:0] weight;
      logic                   last_edge;
   } req_beat_type;

   typedef struct packed {
      logic [CostWidth-1:0] total_cost;
   } rsp_beat_type;

   // Level setup seen by the classifier
   typedef struct packed {
      logic [LevelWidth-1:0]              top_level;
      logic [HwLevels-1:0][DistWidth-1:0] distance;
   } level_cfg_type;

   // Reciprocals of the level strides and their status
   typedef struct packed {
      logic                  busy;
      logic                  big2;
      logic [RecipWidth-1:0] recip1;
      logic [RecipWidth-1:0] recip2;
   } recip_type;

   // Classified edge waiting for the back end
   typedef struct packed {
      logic [WeightWidth-1:0] weight;
      logic [DistWidth-1:0]   distance;
      logic                   last_edge;
   } work_type;

endpackage

`default_nettype wire

@@ hw/rtl/hmca_chan_if.sv @@
`default_nettype none

// Edge beat channel
interface hmca_req_if;
   logic                  valid;
   logic                  ready;
   hmca_pkg::req_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// Total cost channel
interface hmca_rsp_if;
   logic                  valid;
   logic                  ready;
   hmca_pkg::rsp_beat_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/hmca_stride.sv @@
`default_nettype none

// Works out stride reciprocals ceil(2^32 / stride) for levels 1 and 2
// with one shared restoring divider, one quotient bit per cycle.
module hmca_stride (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   input  wire logic [hmca_pkg::PartsWidth-1:0]     parts0,
   input  wire logic [hmca_pkg::PartsWidth-1:0]     parts1,
   output hmca_pkg::recip_type                      recip
);

   localparam int SW = hmca_pkg::StrideWidth;
   localparam int QW = hmca_pkg::RecipShift;
   localparam int CW = $clog2(QW);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV1,
      ST_DIV2
   } state_type;

   state_type                          state_ff;
   logic [SW-1:0]                      stride2_ff;
   logic [SW-1:0]                      rem_ff;
   logic [QW-1:0]                      quo_ff;
   logic [CW-1:0]                      bit_cnt_ff;
   logic [hmca_pkg::RecipWidth-1:0]    recip1_ff;
   logic [hmca_pkg::RecipWidth-1:0]    recip2_ff;
   logic                               big2_ff;

   logic [SW-1:0]                      divisor;
   logic [SW:0]                        shifted;
   logic                               ge;
   logic [SW-1:0]                      rem_in;
   logic [QW-1:0]                      quo_in;
   logic [hmca_pkg::RecipWidth-1:0]    recip_in;

   // One divider step on dividend 2^32-1: bring in a one, subtract if it fits
   always_comb begin
      divisor  = (state_ff == ST_DIV1) ? SW'(parts0) : stride2_ff;
      shifted  = {rem_ff, 1'b1};
      ge       = (shifted >= {1'b0, divisor});
      rem_in   = ge ? SW'(shifted - {1'b0, divisor}) : SW'(shifted);
      quo_in   = {quo_ff[QW-2:0], ge};
      recip_in = {1'b0, quo_in} + hmca_pkg::RecipWidth'(1);
   end

   // Sequencer: product stride, then two divisions
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_MUL;
      end else if (start) begin
         state_ff <= ST_MUL;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               state_ff <= ST_IDLE;
            end
            ST_MUL: begin
               stride2_ff <= SW'(parts0) * SW'(parts1);
               rem_ff     <= '0;
               quo_ff     <= '0;
               bit_cnt_ff <= CW'(QW - 1);
               state_ff   <= ST_DIV1;
            end
            ST_DIV1: begin
               rem_ff     <= rem_in;
               quo_ff     <= quo_in;
               bit_cnt_ff <= bit_cnt_ff - CW'(1);
               if (bit_cnt_ff == '0) begin
                  recip1_ff  <= recip_in;
                  rem_ff     <= '0;
                  quo_ff     <= '0;
                  bit_cnt_ff <= CW'(QW - 1);
                  state_ff   <= ST_DIV2;
               end
            end
            ST_DIV2: begin
               rem_ff     <= rem_in;
               quo_ff     <= quo_in;
               bit_cnt_ff <= bit_cnt_ff - CW'(1);
               if (bit_cnt_ff == '0) begin
                  recip2_ff <= recip_in;
                  // stride at or above 2^16: every id has quotient zero
                  big2_ff   <= (stride2_ff[SW-1:hmca_pkg::IdWidth] != '0);
                  state_ff  <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_MUL;
            end
         endcase
      end
   end

   assign recip.busy   = (state_ff != ST_IDLE);
   assign recip.big2   = big2_ff;
   assign recip.recip1 = recip1_ff;
   assign recip.recip2 = recip2_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hmca_front.sv @@
`default_nettype none

// Front end: takes edge beats, splits ids into level quotients by
// reciprocal multiply, picks the distance of the highest differing level.
module hmca_front (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       hold,
   input  wire hmca_pkg::recip_type        recip,
   input  wire hmca_pkg::level_cfg_type    cfg,
   hmca_req_if.sink                        req_chan,
   output logic                            push_valid,
   output hmca_pkg::work_type              push_data,
   input  wire logic                       push_ready
);

   localparam int IW = hmca_pkg::IdWidth;
   localparam int PW = hmca_pkg::ProdWidth;
   localparam int RS = hmca_pkg::RecipShift;

   logic                         s1_valid_ff;
   hmca_pkg::req_beat_type       s1_beat_ff;

   logic                         s2_valid_ff;
   logic                         s2_diff_ff;
   logic [IW-1:0]                s2_q1s_ff;
   logic [IW-1:0]                s2_q1d_ff;
   logic [IW-1:0]                s2_q2s_ff;
   logic [IW-1:0]                s2_q2d_ff;
   logic [hmca_pkg::WeightWidth-1:0] s2_weight_ff;
   logic                         s2_last_ff;

   logic                         adv;
   logic [PW-1:0]                prod_1s;
   logic [PW-1:0]                prod_1d;
   logic [PW-1:0]                prod_2s;
   logic [PW-1:0]                prod_2d;
   logic [hmca_pkg::DistWidth-1:0] dist_sel;

   assign adv            = !s2_valid_ff || push_ready;
   assign req_chan.ready = adv && !hold;

   // Quotient id / stride = (id * recip) >> 32, exact for 16-bit ids
   assign prod_1s = PW'(s1_beat_ff.src_block) * PW'(recip.recip1);
   assign prod_1d = PW'(s1_beat_ff.dst_block) * PW'(recip.recip1);
   assign prod_2s = PW'(s1_beat_ff.src_block) * PW'(recip.recip2);
   assign prod_2d = PW'(s1_beat_ff.dst_block) * PW'(recip.recip2);

   // Input register and quotient register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_chan.valid && req_chan.ready;
         s2_valid_ff <= s1_valid_ff;
      end
      if (adv) begin
         s1_beat_ff   <= req_chan.data;
         s2_diff_ff   <= (s1_beat_ff.src_block != s1_beat_ff.dst_block);
         s2_q1s_ff    <= prod_1s[RS+IW-1:RS];
         s2_q1d_ff    <= prod_1d[RS+IW-1:RS];
         s2_q2s_ff    <= recip.big2 ? '0 : prod_2s[RS+IW-1:RS];
         s2_q2d_ff    <= recip.big2 ? '0 : prod_2d[RS+IW-1:RS];
         s2_weight_ff <= s1_beat_ff.weight;
         s2_last_ff   <= s1_beat_ff.last_edge;
      end
   end

   // Highest level whose quotients differ; level 0 differs whenever ids do
   always_comb begin
      if (!s2_diff_ff) begin
         dist_sel = '0;
      end else if (cfg.top_level == 2'd2 && s2_q2s_ff != s2_q2d_ff) begin
         dist_sel = cfg.distance[2];
      end else if (cfg.top_level != 2'd0 && s2_q1s_ff != s2_q1d_ff) begin
         dist_sel = cfg.distance[1];
      end else begin
         dist_sel = cfg.distance[0];
      end
   end

   assign push_valid          = s2_valid_ff;
   assign push_data.weight    = s2_weight_ff;
   assign push_data.distance  = dist_sel;
   assign push_data.last_edge = s2_last_ff;

endmodule

`default_nettype wire

@@ hw/rtl/hmca_fifo.sv @@
`default_nettype none

// Short queue of classified edges between front and back end
module hmca_fifo (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  push_valid,
   input  wire hmca_pkg::work_type    push_data,
   output logic                       push_ready,
   output logic                       pop_valid,
   output hmca_pkg::work_type         pop_data,
   input  wire logic                  pop_ready
);

   localparam int DP = hmca_pkg::QueueDepth;
   localparam int PT = hmca_pkg::QueuePtrWidth;
   localparam int CT = hmca_pkg::QueueCntWidth;

   hmca_pkg::work_type   mem_ff [DP];
   logic [PT-1:0]        wr_ptr_ff;
   logic [PT-1:0]        rd_ptr_ff;
   logic [CT-1:0]        count_ff;

   logic                 push;
   logic                 pop;

   assign push_ready = (count_ff != CT'(DP));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   // Pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PT'(DP - 1)) ? '0 : wr_ptr_ff + PT'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PT'(DP - 1)) ? '0 : rd_ptr_ff + PT'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CT'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CT'(1);
         end
      end
   end

   // Storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + CT'(1)))
      else $error("queue count did not grow on push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CT'(DP)) || (count_ff == CT'((wr_ptr_ff - rd_ptr_ff) & PT'(DP - 1)))
      || (wr_ptr_ff >= rd_ptr_ff && count_ff == CT'(wr_ptr_ff - rd_ptr_ff))
      || (wr_ptr_ff < rd_ptr_ff && count_ff == CT'(DP) - CT'(rd_ptr_ff - wr_ptr_ff)))
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

@@ hw/rtl/hmca_back.sv @@
`default_nettype none

// Back end: weight * distance, saturating 64-bit sum, result register
module hmca_back (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  pop_valid,
   input  wire hmca_pkg::work_type    pop_data,
   output logic                       pop_ready,
   hmca_rsp_if.source                 rsp_chan
);

   localparam int CW = hmca_pkg::CostWidth;
   localparam int MW = hmca_pkg::CostProdWidth;

   logic            m_valid_ff;
   logic [MW-1:0]   m_prod_ff;
   logic            m_last_ff;
   logic [CW-1:0]   acc_ff;
   logic            rsp_valid_ff;
   logic [CW-1:0]   rsp_total_ff;

   logic            m_take;
   logic [CW:0]     sum_in;
   logic [CW-1:0]   sat_in;

   // A last beat waits until the result register is free
   assign m_take    = m_valid_ff && (!m_last_ff || !rsp_valid_ff || rsp_chan.ready);
   assign pop_ready = !m_valid_ff || m_take;

   assign sum_in = {1'b0, acc_ff} + (CW + 1)'(m_prod_ff);
   assign sat_in = sum_in[CW] ? '1 : sum_in[CW-1:0];

   // Product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         m_valid_ff <= 1'b0;
      end else if (pop_ready) begin
         m_valid_ff <= pop_valid;
      end
      if (pop_ready && pop_valid) begin
         m_prod_ff <= MW'(pop_data.weight) * MW'(pop_data.distance);
         m_last_ff <= pop_data.last_edge;
      end
   end

   // Accumulator and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (m_take) begin
            acc_ff <= m_last_ff ? '0 : sat_in;
         end
         if (m_take && m_last_ff) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (m_take && m_last_ff) begin
         rsp_total_ff <= sat_in;
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.data.total_cost = rsp_total_ff;

   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      (m_take && m_last_ff) |=> (rsp_valid_ff && acc_ff == '0))
      else $error("last beat did not post a result and clear the sum");

   a_sat_sticks: assert property (@(posedge clock) disable iff (reset)
      (acc_ff == '1 && !(m_take && m_last_ff)) |=> (acc_ff == '1))
      else $error("saturated sum left its maximum");

endmodule

`default_nettype wire

@@ hw/rtl/hierarchical_mapping_cost_accumulator_core.sv @@
// Hierarchical mapping cost accumulator. Each req beat is one weighted edge (source
// block id, target block id, weight, last flag); ids are mixed-radix numbers over up to
// three hierarchy levels set by the parts registers. For different ids the block adds
// weight times the distance of the highest level whose digits differ to a saturating
// 64-bit sum, and the beat flagged last posts the total on rsp and clears the sum.
// Beats are taken one per clock while req ready is high: the front end and the back
// end each handle a beat per cycle unless held by back-pressure, and a four-entry
// queue sits between them. After reset and after every csr write the block forms the
// level-2 stride, then computes stride reciprocals in a shared one-bit-per-cycle
// divider and holds req ready low meanwhile; csr writes are taken at any time.
`default_nettype none

module hierarchical_mapping_cost_accumulator_core #(
   parameter int MAX_LEVELS = 3
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  csr_write_en,
   input  wire logic [hmca_pkg::CsrIndexWidth-1:0]    csr_index,
   input  wire logic [hmca_pkg::CsrDataWidth-1:0]     csr_wdata,
   hmca_req_if.sink                                   req_chan,
   hmca_rsp_if.source                                 rsp_chan
);

   localparam int LW = hmca_pkg::LevelWidth;
   localparam int PW = hmca_pkg::PartsWidth;
   localparam int DW = hmca_pkg::DistWidth;
   localparam int HL = hmca_pkg::HwLevels;

   logic [LW-1:0]          level_count_ff;
   logic [HL-1:0][PW-1:0]  parts_ff;
   logic [HL-1:0][DW-1:0]  dist_ff;

   logic [LW-1:0]          levels_used;
   logic [PW-1:0]          parts0_eff;
   logic [PW-1:0]          parts1_eff;
   hmca_pkg::level_cfg_type level_cfg;
   hmca_pkg::recip_type    recip;

   logic                   push_valid;
   hmca_pkg::work_type     push_data;
   logic                   push_ready;
   logic                   pop_valid;
   hmca_pkg::work_type     pop_data;
   logic                   pop_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         level_count_ff <= LW'(1);
         parts_ff       <= {HL{PW'(1)}};
         dist_ff        <= '0;
      end else if (csr_write_en) begin
         case (hmca_pkg::csr_index_type'(csr_index))
            hmca_pkg::CSR_LEVEL_COUNT: level_count_ff <= csr_wdata[LW-1:0];
            hmca_pkg::CSR_PARTS0:      parts_ff[0]    <= csr_wdata[PW-1:0];
            hmca_pkg::CSR_PARTS1:      parts_ff[1]    <= csr_wdata[PW-1:0];
            hmca_pkg::CSR_PARTS2:      parts_ff[2]    <= csr_wdata[PW-1:0];
            hmca_pkg::CSR_DIST0:       dist_ff[0]     <= csr_wdata[DW-1:0];
            hmca_pkg::CSR_DIST1:       dist_ff[1]     <= csr_wdata[DW-1:0];
            hmca_pkg::CSR_DIST2:       dist_ff[2]     <= csr_wdata[DW-1:0];
            default: begin
            end
         endcase
      end
   end

   // Clamp level count, zero parts count as one
   always_comb begin
      if (level_count_ff == '0) begin
         levels_used = LW'(1);
      end else if (int'(level_count_ff) > MAX_LEVELS) begin
         levels_used = LW'(MAX_LEVELS);
      end else begin
         levels_used = level_count_ff;
      end
      parts0_eff          = (parts_ff[0] == '0) ? PW'(1) : parts_ff[0];
      parts1_eff          = (parts_ff[1] == '0) ? PW'(1) : parts_ff[1];
      level_cfg.top_level = levels_used - LW'(1);
      level_cfg.distance  = dist_ff;
   end

   hmca_stride u_stride (
      .clock  (clock),
      .reset  (reset),
      .start  (csr_write_en),
      .parts0 (parts0_eff),
      .parts1 (parts1_eff),
      .recip  (recip)
   );

   hmca_front u_front (
      .clock      (clock),
      .reset      (reset),
      .hold       (recip.busy || csr_write_en),
      .recip      (recip),
      .cfg        (level_cfg),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready)
   );

   hmca_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_data   (pop_data),
      .pop_ready  (pop_ready)
   );

   hmca_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

   a_no_beat_busy: assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready) |-> !recip.busy)
      else $error("edge beat taken while stride reciprocals are stale");

   a_csr_restarts: assert property (@(posedge clock) disable iff (reset)
      csr_write_en |=> recip.busy)
      else $error("csr write did not restart the reciprocal pass");

endmodule

`default_nettype wire
